FILE: rtl/wsm_pkg.sv
// Shared definitions for the wildcard string matcher: sizes, character codes,
// command and result types, and the case folding function.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package wsm_pkg;

  // Buffer sizes and derived widths.
  localparam int unsigned PATTERN_DEPTH = 64;
  localparam int unsigned SUBJECT_DEPTH = 256;
  localparam int unsigned CP_W          = 21;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned P_IDX_W       = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int unsigned P_LEN_W       = $clog2(PATTERN_DEPTH + 1);
  localparam int unsigned S_IDX_W       = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;
  localparam int unsigned S_LEN_W       = $clog2(SUBJECT_DEPTH + 1);
  localparam int unsigned S_BACK_W      = $clog2(SUBJECT_DEPTH + 2);

  // Command queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned Q_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Kind codes as seen on the input port.
  localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUBJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVAL    = 2'd2;

  // Character codes.
  localparam logic [CP_W-1:0] CH_STAR  = 21'h00002A;
  localparam logic [CP_W-1:0] CH_QUEST = 21'h00003F;
  localparam logic [CP_W-1:0] LOWER_A  = 21'h000061;
  localparam logic [CP_W-1:0] LOWER_Z  = 21'h00007A;
  localparam logic [CP_W-1:0] CASE_OFS = 21'h000020;

  typedef enum logic [1:0] {
    OP_PAT,
    OP_SUBJ,
    OP_EVAL
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CP_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic matched;
    logic overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_CMP,
    ST_TAIL,
    ST_TAIL_CMP
  } state_e;

  // Folds ASCII lower case letters to upper case; all else passes unchanged.
  // The wildcard codes are not letters, so folding never changes them.
  function automatic logic [CP_W-1:0] fold_case(input logic [CP_W-1:0] c);
    logic [CP_W-1:0] r;
    r = c;
    if ((c >= LOWER_A) && (c <= LOWER_Z)) begin
      r = c - CASE_OFS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wsm_front.sv
// Front part of the wildcard string matcher: classifies an accepted word into
// a queue command and folds its character. Depends on wsm_pkg.
`default_nettype none

module wsm_front (
  input  wire logic                      accept_i,
  input  wire logic [wsm_pkg::KIND_W-1:0] kind_i,
  input  wire logic [wsm_pkg::CP_W-1:0]   code_point_i,
  output      logic                      push_o,
  output      wsm_pkg::cmd_t             cmd_o
);

  always_comb begin
    push_o    = 1'b0;
    cmd_o.op  = wsm_pkg::OP_EVAL;
    // Characters are stored folded, so the back part compares them directly.
    cmd_o.ch  = wsm_pkg::fold_case(code_point_i);
    unique case (kind_i)
      wsm_pkg::KIND_PATTERN: begin
        push_o   = accept_i;
        cmd_o.op = wsm_pkg::OP_PAT;
      end
      wsm_pkg::KIND_SUBJECT: begin
        push_o   = accept_i;
        cmd_o.op = wsm_pkg::OP_SUBJ;
      end
      wsm_pkg::KIND_EVAL: begin
        push_o   = accept_i;
        cmd_o.op = wsm_pkg::OP_EVAL;
      end
      default: begin
        // The unused kind is dropped here and never reaches the queue.
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/wsm_queue.sv
// Short command queue between the front and back parts of the matcher.
// Depends on wsm_pkg for the command type and queue depth.
`default_nettype none

module wsm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wsm_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output      wsm_pkg::cmd_t cmd_o,
  output      logic          empty_o,
  output      logic          full_o
);

  localparam logic [wsm_pkg::Q_PTR_W-1:0] PtrLast = wsm_pkg::Q_PTR_W'(wsm_pkg::QUEUE_DEPTH - 1);
  localparam logic [wsm_pkg::Q_CNT_W-1:0] CntFull = wsm_pkg::Q_CNT_W'(wsm_pkg::QUEUE_DEPTH);

  wsm_pkg::cmd_t                   entries_q [wsm_pkg::QUEUE_DEPTH];
  logic [wsm_pkg::Q_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [wsm_pkg::Q_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [wsm_pkg::Q_CNT_W-1:0]     count_q, count_d;
  logic                            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wsm_back.sv
// Back part of the matcher: holds the pattern and subject buffers, applies
// append commands and runs the greedy backtracking match. Depends on wsm_pkg.
`default_nettype none

module wsm_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire wsm_pkg::cmd_t   cmd_i,
  input  wire logic            empty_i,
  output      logic            pop_o,
  output      wsm_pkg::result_t result_o
);

  localparam logic [wsm_pkg::P_LEN_W-1:0] PatFull  = wsm_pkg::P_LEN_W'(wsm_pkg::PATTERN_DEPTH);
  localparam logic [wsm_pkg::S_LEN_W-1:0] SubjFull = wsm_pkg::S_LEN_W'(wsm_pkg::SUBJECT_DEPTH);

  // Buffer memories with registered reads.
  logic [wsm_pkg::CP_W-1:0] pat_mem  [wsm_pkg::PATTERN_DEPTH];
  logic [wsm_pkg::CP_W-1:0] subj_mem [wsm_pkg::SUBJECT_DEPTH];
  logic [wsm_pkg::CP_W-1:0] pat_rd_q, subj_rd_q;
  logic                     pat_we, subj_we;

  wsm_pkg::state_e              state_q, state_d;
  logic [wsm_pkg::P_LEN_W-1:0]  plen_q, plen_d;
  logic [wsm_pkg::S_LEN_W-1:0]  slen_q, slen_d;
  logic                         ovf_q, ovf_d;
  logic [wsm_pkg::P_LEN_W-1:0]  wi_q, wi_d;
  logic [wsm_pkg::S_LEN_W-1:0]  si_q, si_d;
  logic [wsm_pkg::P_LEN_W-1:0]  back_w_q, back_w_d;
  logic [wsm_pkg::S_BACK_W-1:0] back_s_q, back_s_d;
  logic                         have_back_q, have_back_d;
  wsm_pkg::result_t             res_q, res_d;

  logic                         p_in, p_star, p_hit, s_end, star_last;
  logic [wsm_pkg::P_LEN_W-1:0]  wi_inc;
  logic [wsm_pkg::S_LEN_W-1:0]  si_inc;

  assign p_in      = (wi_q < plen_q);
  assign p_star    = (pat_rd_q == wsm_pkg::CH_STAR);
  assign p_hit     = (pat_rd_q == wsm_pkg::CH_QUEST) || (pat_rd_q == subj_rd_q);
  assign s_end     = (si_q >= slen_q);
  assign wi_inc    = wi_q + 1'b1;
  assign si_inc    = si_q + 1'b1;
  assign star_last = (wi_inc >= plen_q);
  assign result_o  = res_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsm_pkg::ST_IDLE: begin
        if (!empty_i && (cmd_i.op == wsm_pkg::OP_EVAL) && !ovf_q) begin
          state_d = wsm_pkg::ST_LOOP;
        end
      end
      wsm_pkg::ST_LOOP: begin
        state_d = s_end ? wsm_pkg::ST_TAIL : wsm_pkg::ST_CMP;
      end
      wsm_pkg::ST_CMP: begin
        priority if (p_in && p_star) begin
          state_d = star_last ? wsm_pkg::ST_IDLE : wsm_pkg::ST_LOOP;
        end else if (p_in && p_hit) begin
          state_d = wsm_pkg::ST_LOOP;
        end else begin
          state_d = have_back_q ? wsm_pkg::ST_LOOP : wsm_pkg::ST_IDLE;
        end
      end
      wsm_pkg::ST_TAIL: begin
        state_d = p_in ? wsm_pkg::ST_TAIL_CMP : wsm_pkg::ST_IDLE;
      end
      wsm_pkg::ST_TAIL_CMP: begin
        state_d = p_star ? wsm_pkg::ST_TAIL : wsm_pkg::ST_IDLE;
      end
      default: begin
        state_d = wsm_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pop_o       = 1'b0;
    pat_we      = 1'b0;
    subj_we     = 1'b0;
    plen_d      = plen_q;
    slen_d      = slen_q;
    ovf_d       = ovf_q;
    wi_d        = wi_q;
    si_d        = si_q;
    back_w_d    = back_w_q;
    back_s_d    = back_s_q;
    have_back_d = have_back_q;
    res_d       = '0;
    unique case (state_q)
      wsm_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            wsm_pkg::OP_PAT: begin
              if (plen_q < PatFull) begin
                pat_we = 1'b1;
                plen_d = plen_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            wsm_pkg::OP_SUBJ: begin
              if (slen_q < SubjFull) begin
                subj_we = 1'b1;
                slen_d  = slen_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            wsm_pkg::OP_EVAL: begin
              if (ovf_q) begin
                res_d  = '{valid: 1'b1, matched: 1'b0, overflow: 1'b1};
                plen_d = '0;
                slen_d = '0;
                ovf_d  = 1'b0;
              end else begin
                wi_d        = '0;
                si_d        = '0;
                have_back_d = 1'b0;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      wsm_pkg::ST_LOOP: begin
        // Addresses are held this cycle so the buffer reads land for the compare.
      end
      wsm_pkg::ST_CMP: begin
        priority if (p_in && p_star) begin
          wi_d = wi_inc;
          if (star_last) begin
            res_d  = '{valid: 1'b1, matched: 1'b1, overflow: 1'b0};
            plen_d = '0;
            slen_d = '0;
          end else begin
            back_w_d    = wi_inc;
            back_s_d    = wsm_pkg::S_BACK_W'(si_q) + 1'b1;
            have_back_d = 1'b1;
          end
        end else if (p_in && p_hit) begin
          wi_d = wi_inc;
          si_d = si_inc;
        end else if (have_back_q) begin
          wi_d     = back_w_q;
          si_d     = back_s_q[wsm_pkg::S_LEN_W-1:0];
          back_s_d = back_s_q + 1'b1;
        end else begin
          res_d  = '{valid: 1'b1, matched: 1'b0, overflow: 1'b0};
          plen_d = '0;
          slen_d = '0;
        end
      end
      wsm_pkg::ST_TAIL: begin
        if (!p_in) begin
          res_d  = '{valid: 1'b1, matched: 1'b1, overflow: 1'b0};
          plen_d = '0;
          slen_d = '0;
        end
      end
      wsm_pkg::ST_TAIL_CMP: begin
        if (p_star) begin
          wi_d = wi_inc;
        end else begin
          res_d  = '{valid: 1'b1, matched: 1'b0, overflow: 1'b0};
          plen_d = '0;
          slen_d = '0;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsm_pkg::ST_IDLE;
      plen_q      <= '0;
      slen_q      <= '0;
      ovf_q       <= 1'b0;
      wi_q        <= '0;
      si_q        <= '0;
      back_w_q    <= '0;
      back_s_q    <= '0;
      have_back_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      slen_q      <= slen_d;
      ovf_q       <= ovf_d;
      wi_q        <= wi_d;
      si_q        <= si_d;
      back_w_q    <= back_w_d;
      back_s_q    <= back_s_d;
      have_back_q <= have_back_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[plen_q[wsm_pkg::P_IDX_W-1:0]] <= cmd_i.ch;
    end
    pat_rd_q <= pat_mem[wi_q[wsm_pkg::P_IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (subj_we) begin
      subj_mem[slen_q[wsm_pkg::S_IDX_W-1:0]] <= cmd_i.ch;
    end
    subj_rd_q <= subj_mem[si_q[wsm_pkg::S_IDX_W-1:0]];
  end

endmodule

`default_nettype wire

FILE: rtl/wildcard_string_matcher_core.sv
// An accepted append word passes through the queue and is then written into its buffer. An
// evaluate word gives its result word from the idle state when an overflow is pending, else
// after the match walk (each step waits on the registered reads of both buffer RAMs), the tail
// check and a step per trailing star. Appends sustain one word per cycle while no evaluation
// runs; busy rises while the four-word queue is full, and the receiver cannot stall results.
// Reset is asynchronous and clears the lengths, the overflow flag and the queue; buffers stay.
`default_nettype none

module wildcard_string_matcher_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [wsm_pkg::KIND_W-1:0] kind_i,
  input  wire logic [wsm_pkg::CP_W-1:0]   code_point_i,
  output      logic                       done_o,
  output      logic                       matched_o,
  output      logic                       overflow_o
);

  // The front part classifies each accepted word and folds its character; a kind
  // that means nothing is dropped there. Commands then wait in a short queue, so
  // the caller can keep loading characters while the back part walks the buffers.
  logic             accept;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  wsm_pkg::cmd_t    front_cmd;
  wsm_pkg::cmd_t    head_cmd;
  wsm_pkg::result_t result;

  // A word is taken whenever the queue has room.
  assign busy   = q_full;
  assign accept = start && !busy;

  wsm_front u_front (
    .accept_i     (accept),
    .kind_i       (kind_i),
    .code_point_i (code_point_i),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  wsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // The back part applies appends one at a time and runs the match for an
  // evaluate word. Its result register drives the outputs for exactly one cycle.
  wsm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (head_cmd),
    .empty_i  (q_empty),
    .pop_o    (pop),
    .result_o (result)
  );

  assign done_o     = result.valid;
  assign matched_o  = result.matched;
  assign overflow_o = result.overflow;

endmodule

`default_nettype wire

FILE: rtl/wsm_checker.sv
// Port-level checker for the wildcard string matcher, bound to the top level.
// Depends on wsm_pkg for the kind codes.
`default_nettype none

module wsm_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [wsm_pkg::KIND_W-1:0] kind_i,
  input wire logic [wsm_pkg::CP_W-1:0]   code_point_i,
  input wire logic                       done_o,
  input wire logic                       matched_o,
  input wire logic                       overflow_o
);

  // Count of evaluate words accepted whose result has not yet been shown.
  logic [3:0] pend_q, pend_d;
  logic       eval_acc;

  assign eval_acc = start && !busy && (kind_i == wsm_pkg::KIND_EVAL);

  always_comb begin
    pend_d = pend_q;
    if (eval_acc && !done_o) begin
      pend_d = pend_q + 1'b1;
    end else if (done_o && !eval_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_result_has_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pend_q != 4'd0))
    else $error("result shown without a pending evaluate word");

  a_overflow_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> !matched_o)
    else $error("match reported together with overflow");

  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !done_o)
    else $error("result shown right after reset");

  a_not_busy_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 4'd0 && $past(pend_q) == 4'd0 && !$past(start)) |-> !busy)
    else $error("busy while nothing is queued");

endmodule

bind wildcard_string_matcher_core wsm_checker u_wsm_checker (.*);

`default_nettype wire

FILE: dv/tb_wildcard_string_matcher_core.sv
// Self-checking testbench for wildcard_string_matcher_core: glob matching with '*' and '?'.
// Needs rtl/wsm_pkg.sv and the core with its parts. A queue-fed driver, a built-in predictor and a
// result monitor check every evaluate word against the expected match and overflow bits.
`default_nettype none

module tb_wildcard_string_matcher_core;

  // Kind code 3 is unused by the block; words with it must be ignored.
  localparam logic [wsm_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;

  // The stall limit leaves a wide margin over the worst evaluate walk.
  localparam int STALL_LIMIT  = 150000;
  // Cycles to watch for stray result words once everything has been checked.
  localparam int SETTLE       = 200;
  // Stimulus stops once this many non-ignored words have been queued.
  localparam int WORD_TARGET  = 550;

  typedef struct packed {
    logic [wsm_pkg::KIND_W-1:0] kind;
    logic [wsm_pkg::CP_W-1:0]   cp;
  } word_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic                       clk_i;
  logic                       rst_ni       = 1'b0;
  logic                       start        = 1'b0;
  logic                       busy;
  logic [wsm_pkg::KIND_W-1:0] kind_i       = wsm_pkg::KIND_PATTERN;
  logic [wsm_pkg::CP_W-1:0]   code_point_i = '0;
  logic                       done_o;
  logic                       matched_o;
  logic                       overflow_o;

  wildcard_string_matcher_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .code_point_i (code_point_i),
    .done_o       (done_o),
    .matched_o    (matched_o),
    .overflow_o   (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Words waiting to be offered, and the one currently on the input ports.
  word_t          pending_words[$];
  word_t          offered_word;
  int             total_words;
  int             issued_words = 0;
  int             gen_count    = 0;

  // Verdicts predicted for accepted evaluate words, oldest first.
  verdict_t       expected_verdicts[$];
  int             mismatches   = 0;
  int             quiet_cycles = 0;

  // Scratch buffers used while building one pattern/subject pair.
  logic [wsm_pkg::CP_W-1:0] pat_q[$];
  logic [wsm_pkg::CP_W-1:0] subj_q[$];

  // Predictor state: a private copy of both buffers, their fill levels and the
  // sticky overflow flag.
  logic [wsm_pkg::CP_W-1:0] pat_chars  [wsm_pkg::PATTERN_DEPTH];
  logic [wsm_pkg::CP_W-1:0] subj_chars [wsm_pkg::SUBJECT_DEPTH];
  int unsigned              pat_len    = 0;
  int unsigned              subj_len   = 0;
  bit                       ovf_sticky = 1'b0;

  // Case folding covers only the ASCII lower case letters; clearing bit 5 maps
  // them onto their upper case partners.
  function automatic logic [wsm_pkg::CP_W-1:0] upcase_ascii(
      input logic [wsm_pkg::CP_W-1:0] c);
    if (c >= wsm_pkg::LOWER_A && c <= wsm_pkg::LOWER_Z) begin
      return c & ~wsm_pkg::CASE_OFS;
    end
    return c;
  endfunction

  // Greedy backtracking glob walk over the predictor's buffers. Only the last
  // star is remembered: on a mismatch the walk retries one subject character
  // further along from that star.
  function automatic bit glob_match();
    int unsigned si;
    int unsigned wi;
    int unsigned back_s;
    int unsigned back_w;
    bit          have_back;
    si        = 0;
    wi        = 0;
    back_s    = 0;
    back_w    = 0;
    have_back = 1'b0;
    while (si < subj_len) begin
      if (wi < pat_len && pat_chars[wi] == wsm_pkg::CH_STAR) begin
        wi++;
        // A trailing star swallows whatever subject is left.
        if (wi >= pat_len) begin
          return 1'b1;
        end
        back_w    = wi;
        back_s    = si + 1;
        have_back = 1'b1;
      end else if (wi < pat_len && (pat_chars[wi] == wsm_pkg::CH_QUEST ||
                   upcase_ascii(pat_chars[wi]) == upcase_ascii(subj_chars[si]))) begin
        wi++;
        si++;
      end else begin
        if (!have_back) begin
          return 1'b0;
        end
        wi = back_w;
        si = back_s;
        back_s++;
      end
    end
    // The subject is used up; only stars may remain in the pattern.
    while (wi < pat_len && pat_chars[wi] == wsm_pkg::CH_STAR) begin
      wi++;
    end
    return wi >= pat_len;
  endfunction

  // Updates the predictor for one accepted word. Appends to a full buffer are
  // dropped and flagged; an evaluate after an overflow never reports a match.
  task automatic apply_word(input word_t w);
    verdict_t v;
    case (w.kind)
      wsm_pkg::KIND_PATTERN: begin
        if (pat_len < wsm_pkg::PATTERN_DEPTH) begin
          pat_chars[pat_len] = w.cp;
          pat_len++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      wsm_pkg::KIND_SUBJECT: begin
        if (subj_len < wsm_pkg::SUBJECT_DEPTH) begin
          subj_chars[subj_len] = w.cp;
          subj_len++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      wsm_pkg::KIND_EVAL: begin
        v.overflow = ovf_sticky;
        v.matched  = ovf_sticky ? 1'b0 : glob_match();
        expected_verdicts.push_back(v);
        pat_len    = 0;
        subj_len   = 0;
        ovf_sticky = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_word(input logic [wsm_pkg::KIND_W-1:0] k,
                           input logic [wsm_pkg::CP_W-1:0] c);
    word_t w;
    w.kind = k;
    w.cp   = c;
    pending_words.push_back(w);
    if (k != KIND_IGNORED) begin
      gen_count++;
    end
  endtask

  // Mostly a small alphabet (a, b, c in both cases) so that matches are common,
  // with the wildcards on request and now and then code point zero or a random
  // 21-bit value.
  function automatic logic [wsm_pkg::CP_W-1:0] pick_char(input bit wild);
    int unsigned r;
    r = $urandom_range(0, 31);
    if (wild && r < 6) begin
      return wsm_pkg::CH_STAR;
    end
    if (wild && r < 10) begin
      return wsm_pkg::CH_QUEST;
    end
    if (r == 31) begin
      return wsm_pkg::CP_W'($urandom());
    end
    if (r == 30) begin
      return '0;
    end
    return wsm_pkg::LOWER_A - (r[0] ? wsm_pkg::CASE_OFS : '0) + wsm_pkg::CP_W'(r % 3);
  endfunction

  // Interleaves the scratch pattern and subject at random, keeping the order
  // within each, optionally sprinkles ignored words in, and closes with an
  // evaluate word.
  task automatic flush_pair(input bit with_noise);
    while (pat_q.size() != 0 || subj_q.size() != 0) begin
      if (with_noise && $urandom_range(0, 7) == 0) begin
        push_word(KIND_IGNORED, wsm_pkg::CP_W'($urandom()));
      end
      if (subj_q.size() == 0 || (pat_q.size() != 0 && $urandom_range(0, 1) == 1)) begin
        push_word(wsm_pkg::KIND_PATTERN, pat_q.pop_front());
      end else begin
        push_word(wsm_pkg::KIND_SUBJECT, subj_q.pop_front());
      end
    end
    push_word(wsm_pkg::KIND_EVAL, wsm_pkg::CP_W'($urandom()));
  endtask

  // Long pair of the given sizes; sizes past the buffer depths overflow.
  task automatic long_pair(input int plen, input int slen);
    repeat (plen) pat_q.push_back(pick_char(1'b1));
    repeat (slen) subj_q.push_back(pick_char(1'b0));
    flush_pair(1'b0);
  endtask

  // The sender rests 28 percent of the time in the first third of the run,
  // 54 percent in the second and never in the last.
  function automatic bit sender_rests();
    int unsigned pct;
    if (issued_words < total_words / 3) begin
      pct = 28;
    end else if (issued_words < (2 * total_words) / 3) begin
      pct = 54;
    end else begin
      pct = 0;
    end
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver. A word is taken at an edge where start is high and busy is low;
  // while busy holds it off the word stays on the ports unchanged. Each edge
  // makes at most one assignment to start.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_word(offered_word);
      end
      if (start && busy) begin
        // Held off: keep offering the same word.
      end else if (pending_words.size() != 0 && !sender_rests()) begin
        offered_word  = pending_words.pop_front();
        issued_words++;
        start        <= 1'b1;
        kind_i       <= offered_word.kind;
        code_point_i <= offered_word.cp;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Every done_o strobe carries one verdict, checked against the
  // oldest prediction. The watchdog counts edges on which neither an input
  // word nor a result word moves.
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (done_o) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with nothing expected: matched %0b overflow %0b",
                 matched_o, overflow_o);
          mismatches++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (matched_o !== exp_v.matched) begin
            $error("matched: expected %0b, got %0b", exp_v.matched, matched_o);
            mismatches++;
          end
          if (overflow_o !== exp_v.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_v.overflow, overflow_o);
            mismatches++;
          end
        end
      end
      if (done_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int                       mode;
    int                       n;
    int                       idx;
    bit                       timed_out;
    logic [wsm_pkg::CP_W-1:0] c;

    // Directed part.
    // Empty pattern against empty subject matches.
    push_word(wsm_pkg::KIND_EVAL, '0);
    // Empty pattern against a non-empty subject does not.
    push_word(wsm_pkg::KIND_SUBJECT, wsm_pkg::LOWER_A);
    push_word(wsm_pkg::KIND_EVAL, '0);
    // Empty subject against a pattern of stars only matches.
    push_word(wsm_pkg::KIND_PATTERN, wsm_pkg::CH_STAR);
    push_word(wsm_pkg::KIND_PATTERN, wsm_pkg::CH_STAR);
    push_word(wsm_pkg::KIND_EVAL, '0);
    // Empty subject against a question mark does not.
    push_word(wsm_pkg::KIND_PATTERN, wsm_pkg::CH_QUEST);
    push_word(wsm_pkg::KIND_EVAL, '1);
    // Case folding of ASCII letters.
    push_word(wsm_pkg::KIND_PATTERN, wsm_pkg::LOWER_A);
    push_word(wsm_pkg::KIND_SUBJECT, wsm_pkg::LOWER_A - wsm_pkg::CASE_OFS);
    push_word(wsm_pkg::KIND_EVAL, '0);
    // Code point zero is an ordinary character.
    push_word(wsm_pkg::KIND_PATTERN, '0);
    push_word(wsm_pkg::KIND_SUBJECT, '0);
    push_word(wsm_pkg::KIND_EVAL, '0);
    // All-ones code point, beyond Unicode, with an ignored word in between.
    push_word(wsm_pkg::KIND_PATTERN, '1);
    push_word(KIND_IGNORED, '1);
    push_word(wsm_pkg::KIND_SUBJECT, '1);
    push_word(wsm_pkg::KIND_EVAL, '0);
    // A star that needs backtracking, then a question mark.
    push_word(wsm_pkg::KIND_PATTERN, wsm_pkg::CH_STAR);
    push_word(wsm_pkg::KIND_PATTERN, wsm_pkg::LOWER_A + 21'd1);
    push_word(wsm_pkg::KIND_PATTERN, wsm_pkg::CH_QUEST);
    push_word(wsm_pkg::KIND_SUBJECT, wsm_pkg::LOWER_A);
    push_word(wsm_pkg::KIND_SUBJECT, wsm_pkg::LOWER_A + 21'd1);
    push_word(wsm_pkg::KIND_SUBJECT, wsm_pkg::LOWER_A + 21'd1 - wsm_pkg::CASE_OFS);
    push_word(wsm_pkg::KIND_EVAL, '0);

    // Buffer extremes: a pattern exactly full with a subject that overflows by
    // one, then a pattern that overflows by one.
    long_pair(wsm_pkg::PATTERN_DEPTH, wsm_pkg::SUBJECT_DEPTH + 1);
    long_pair(wsm_pkg::PATTERN_DEPTH + 1, 3);

    // Random part: mostly well-formed pairs, many built so that the subject
    // fits the pattern, plus broken pairs and raw noise.
    while (gen_count < WORD_TARGET) begin
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
        n = $urandom_range(1, 8);
        repeat (n) push_word(wsm_pkg::KIND_W'($urandom_range(0, 3)),
                             wsm_pkg::CP_W'($urandom()));
        push_word(wsm_pkg::KIND_EVAL, wsm_pkg::CP_W'($urandom()));
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) pat_q.push_back(pick_char(1'b1));
        if (mode < 65) begin
          // Expand each pattern character into a subject that fits it.
          foreach (pat_q[i]) begin
            if (pat_q[i] == wsm_pkg::CH_STAR) begin
              repeat ($urandom_range(0, 3)) subj_q.push_back(pick_char(1'b0));
            end else if (pat_q[i] == wsm_pkg::CH_QUEST) begin
              subj_q.push_back(pick_char(1'b0));
            end else begin
              c = pat_q[i];
              if (upcase_ascii(c | wsm_pkg::CASE_OFS) != (c | wsm_pkg::CASE_OFS)
                  && $urandom_range(0, 1)) begin
                c = c ^ wsm_pkg::CASE_OFS;
              end
              subj_q.push_back(c);
            end
          end
          // Now and then break the fit by changing or dropping one character.
          if (subj_q.size() != 0 && $urandom_range(0, 3) == 0) begin
            idx = $urandom_range(0, subj_q.size() - 1);
            if ($urandom_range(0, 1)) begin
              subj_q[idx] = pick_char(1'b0);
            end else begin
              subj_q.delete(idx);
            end
          end
        end else begin
          n = $urandom_range(0, 8);
          repeat (n) subj_q.push_back(pick_char($urandom_range(0, 4) == 0));
        end
        flush_pair(mode >= 90);
      end
    end
    total_words = pending_words.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Checks run on the falling edge, away from the driver and the monitor.
    do begin
      @(negedge clk_i);
    end while (!(pending_words.size() == 0 && !start && expected_verdicts.size() == 0)
               && quiet_cycles < STALL_LIMIT);
    timed_out = (quiet_cycles >= STALL_LIMIT);
    if (!timed_out) begin
      repeat (SETTLE) @(negedge clk_i);
    end

    if (timed_out) begin
      $error("stalled with %0d words unsent and %0d verdicts outstanding",
             pending_words.size(), expected_verdicts.size());
      $display("== FAIL ==");
    end else if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/wsm_pkg.sv
rtl/wsm_front.sv
rtl/wsm_queue.sv
rtl/wsm_back.sv
rtl/wildcard_string_matcher_core.sv
rtl/wsm_checker.sv
dv/tb_wildcard_string_matcher_core.sv
